// ----- hdl/mssht_pkg.sv -----
// Shared types and widths for the moving-sphere hit-time pipeline.
// Used by the front end, placement and top modules in hdl/; depends on nothing.
`default_nettype none

package mssht_pkg;

	// Internal word widths, fixed by the 32-bit coordinate format.
	localparam int unsigned DISC_W = 134;  // discriminant, b*b +/- a*c
	localparam int unsigned ROOT_W = 67;   // floor square root of the discriminant
	localparam int unsigned BMAG_W = 66;   // magnitude of L.vel
	localparam int unsigned A_W    = 64;   // vel.vel
	localparam int unsigned NUM_W  = 68;   // numerator of the root
	localparam int unsigned T_W    = 32;   // hit time, unsigned Q16.16
	localparam int unsigned POS_W  = 50;   // moving centre at contact
	localparam int unsigned DMAG_W = 50;   // magnitude of centre difference
	localparam int unsigned LEN2_W = 102;  // squared length of the difference
	localparam int unsigned LEN_W  = 51;   // its floor square root
	localparam int unsigned NQ_W   = 17;   // normal component magnitude

	typedef logic signed [31:0] coord_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [DMAG_W-1:0] dmag_t;

	typedef struct packed {
		coord_t      start_x;
		coord_t      start_y;
		coord_t      start_z;
		logic [30:0] moving_radius;
		coord_t      vel_x;
		coord_t      vel_y;
		coord_t      vel_z;
		coord_t      center_x;
		coord_t      center_y;
		coord_t      center_z;
		logic [30:0] fixed_radius;
	} item_in_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] hit_time;
		coord_t      loc_x;
		coord_t      loc_y;
		coord_t      loc_z;
		coord_t      norm_x;
		coord_t      norm_y;
		coord_t      norm_z;
	} item_out_t;

	// Carried alongside the discriminant square root.
	typedef struct packed {
		logic              miss;
		logic              outside;
		logic              bneg;
		logic [BMAG_W-1:0] bmag;
		logic [A_W-1:0]    a;
		coord_t [2:0]      p;
		coord_t [2:0]      v;
		coord_t [2:0]      c;
		logic [30:0]       mr;
	} root_sb_t;

	// Carried alongside the time division.
	typedef struct packed {
		logic         miss;
		coord_t [2:0] p;
		coord_t [2:0] v;
		coord_t [2:0] c;
		logic [30:0]  mr;
	} time_sb_t;

	// Carried alongside the length square root.
	typedef struct packed {
		logic            miss;
		logic [T_W-1:0]  t;
		pos_t [2:0]      pc;
		logic [2:0]      dneg;
		dmag_t [2:0]     dmag;
		logic [30:0]     mr;
	} norm_sb_t;

	// Carried alongside the normal division.
	typedef struct packed {
		logic            miss;
		logic            lzero;
		logic [T_W-1:0]  t;
		pos_t [2:0]      pc;
		logic [2:0]      dneg;
		logic [30:0]     mr;
	} tail_sb_t;

endpackage

`default_nettype wire

// ----- hdl/mssht_isqrt_pipe.sv -----
// Pipelined floor square root, one result bit per register stage.
// Stand-alone; the side band is an opaque vector that travels with each item.
`default_nettype none

module mssht_isqrt_pipe #(
	parameter int unsigned NW  = 134,
	parameter int unsigned SBW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [NW-1:0]   radicand,
	input  logic [SBW-1:0]  sb_in,
	output logic            out_vld,
	output logic [NW/2-1:0] root,
	output logic [SBW-1:0]  sb_out
);

	localparam int unsigned HW = NW / 2;
	localparam int unsigned RW = HW + 2;

	logic [NW-1:0]  rad_s  [HW];
	logic [HW-1:0]  root_s [HW];
	logic [HW-1:0]  rem_s  [HW];
	logic           vld_s  [HW];
	logic [SBW-1:0] sb_s   [HW];

	for (genvar gi = 0; gi < HW; gi++) begin : g_stage
		logic [NW-1:0]  rad_p;
		logic [HW-1:0]  root_p;
		logic [HW-1:0]  rem_p;
		logic           vld_p;
		logic [SBW-1:0] sb_p;
		logic [RW-1:0]  acc;
		logic [RW-1:0]  trial;

		if (gi == 0) begin : g_first
			assign rad_p  = radicand;
			assign root_p = '0;
			assign rem_p  = '0;
			assign vld_p  = in_vld;
			assign sb_p   = sb_in;
		end else begin : g_next
			assign rad_p  = rad_s[gi-1];
			assign root_p = root_s[gi-1];
			assign rem_p  = rem_s[gi-1];
			assign vld_p  = vld_s[gi-1];
			assign sb_p   = sb_s[gi-1];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign acc   = {rem_p, rad_p[NW-1 -: 2]};
		assign trial = {root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[gi] <= rad_p << 2;
				sb_s[gi]  <= sb_p;
				if (acc >= trial) begin
					rem_s[gi]  <= HW'(acc - trial);
					root_s[gi] <= {root_p[HW-2:0], 1'b1};
				end else begin
					rem_s[gi]  <= HW'(acc);
					root_s[gi] <= {root_p[HW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[HW-1];
	assign root    = root_s[HW-1];
	assign sb_out  = sb_s[HW-1];

endmodule

`default_nettype wire

// ----- hdl/mssht_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
// Stand-alone; the caller guarantees the starting remainder is below the divisor.
`default_nettype none

module mssht_div_pipe #(
	parameter int unsigned DW    = 64,
	parameter int unsigned QW    = 32,
	parameter int unsigned LANES = 1,
	parameter int unsigned SBW   = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [DW-1:0]  divisor,
	input  logic [DW-1:0]  rem0 [LANES],
	input  logic [QW-1:0]  low  [LANES],
	input  logic [SBW-1:0] sb_in,
	output logic           out_vld,
	output logic [QW-1:0]  quot [LANES],
	output logic [SBW-1:0] sb_out
);

	logic [DW-1:0]  d_s   [QW];
	logic [DW-1:0]  r_s   [QW][LANES];
	logic [QW-1:0]  lo_s  [QW][LANES];
	logic [QW-1:0]  q_s   [QW][LANES];
	logic           vld_s [QW];
	logic [SBW-1:0] sb_s  [QW];

	for (genvar gi = 0; gi < QW; gi++) begin : g_stage
		logic [DW-1:0]  d_p;
		logic           vld_p;
		logic [SBW-1:0] sb_p;

		if (gi == 0) begin : g_first
			assign d_p   = divisor;
			assign vld_p = in_vld;
			assign sb_p  = sb_in;
		end else begin : g_next
			assign d_p   = d_s[gi-1];
			assign vld_p = vld_s[gi-1];
			assign sb_p  = sb_s[gi-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gi] <= 1'b0;
			end else if (en) begin
				vld_s[gi] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[gi]  <= d_p;
				sb_s[gi] <= sb_p;
			end
		end

		for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
			logic [DW-1:0] r_p;
			logic [QW-1:0] lo_p;
			logic [QW-1:0] q_p;
			logic [DW:0]   t;
			logic          ge;

			if (gi == 0) begin : g_first
				assign r_p  = rem0[gl];
				assign lo_p = low[gl];
				assign q_p  = '0;
			end else begin : g_next
				assign r_p  = r_s[gi-1][gl];
				assign lo_p = lo_s[gi-1][gl];
				assign q_p  = q_s[gi-1][gl];
			end

			assign t  = {r_p, lo_p[QW-1]};
			assign ge = (t >= {1'b0, d_p});

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[gi][gl]  <= ge ? DW'(t - {1'b0, d_p}) : DW'(t);
					lo_s[gi][gl] <= lo_p << 1;
					q_s[gi][gl]  <= {q_p[QW-2:0], ge};
				end
			end
		end
	end

	assign out_vld = vld_s[QW-1];
	assign sb_out  = sb_s[QW-1];
	for (genvar gl = 0; gl < LANES; gl++) begin : g_out
		assign quot[gl] = q_s[QW-1][gl];
	end

endmodule

`default_nettype wire

// ----- hdl/mssht_front.sv -----
// Front end: dot products, grown radius, squared terms and the discriminant.
// Seven register stages; uses mssht_pkg types.
`default_nettype none

module mssht_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  mssht_pkg::item_in_t           item,
	output logic                          out_vld,
	output logic [mssht_pkg::DISC_W-1:0]  disc,
	output mssht_pkg::root_sb_t           sb
);

	mssht_pkg::coord_t pin [3];
	mssht_pkg::coord_t vin [3];
	mssht_pkg::coord_t cin [3];

	assign pin[0] = item.start_x;
	assign pin[1] = item.start_y;
	assign pin[2] = item.start_z;
	assign vin[0] = item.vel_x;
	assign vin[1] = item.vel_y;
	assign vin[2] = item.vel_z;
	assign cin[0] = item.center_x;
	assign cin[1] = item.center_y;
	assign cin[2] = item.center_z;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	// Stage 1: centre difference and grown radius.
	logic signed [32:0] lv_s1 [3];
	mssht_pkg::coord_t  p_s1 [3], v_s1 [3], c_s1 [3];
	logic [30:0]        mr_s1;
	logic [31:0]        rr_s1;

	// Stage 2: products.
	logic [63:0]        vsq_s2 [3];
	logic [65:0]        lsq_s2 [3];
	logic signed [64:0] lvv_s2 [3];
	logic [63:0]        r2_s2;
	mssht_pkg::coord_t  p_s2 [3], v_s2 [3], c_s2 [3];
	logic [30:0]        mr_s2;

	// Stage 3: sums.
	logic [63:0]        a_s3;
	logic [65:0]        l2_s3;
	logic signed [66:0] b_s3;
	logic [63:0]        r2_s3;
	mssht_pkg::coord_t  p_s3 [3], v_s3 [3], c_s3 [3];
	logic [30:0]        mr_s3;

	// Stage 4 onwards: side band plus c magnitude and its partial products.
	mssht_pkg::root_sb_t sb_s4, sb_s5, sb_s6, sb_s7;
	logic [65:0]         cmag_s4;
	logic [65:0]         bb_ll_s5, bb_lh_s5, bb_hh_s5;
	logic [64:0]         ac_ll_s5, ac_lh_s5, ac_hl_s5, ac_hh_s5;
	logic [131:0]        bb_s6;
	logic [129:0]        ac_s6;
	logic [mssht_pkg::DISC_W-1:0] disc_s7;

	logic        bneg_c, outside_c;
	logic [65:0] r2_ext_c;
	mssht_pkg::root_sb_t sb_pass_c;

	assign bneg_c    = b_s3[66];
	assign r2_ext_c  = 66'(r2_s3);
	assign outside_c = (l2_s3 > r2_ext_c);

	// Outside with b*b < a*c passes clear of the sphere.
	always_comb begin
		sb_pass_c      = sb_s6;
		sb_pass_c.miss = sb_s6.miss | (sb_s6.outside & (132'(ac_s6) > bb_s6));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				lv_s1[i]  <= 33'(cin[i]) - 33'(pin[i]);
				p_s1[i]   <= pin[i];
				v_s1[i]   <= vin[i];
				c_s1[i]   <= cin[i];

				vsq_s2[i] <= 64'(v_s1[i] * v_s1[i]);
				lsq_s2[i] <= 66'(lv_s1[i] * lv_s1[i]);
				lvv_s2[i] <= 65'(lv_s1[i] * v_s1[i]);
				p_s2[i]   <= p_s1[i];
				v_s2[i]   <= v_s1[i];
				c_s2[i]   <= c_s1[i];

				p_s3[i]   <= p_s2[i];
				v_s3[i]   <= v_s2[i];
				c_s3[i]   <= c_s2[i];
			end
			mr_s1 <= item.moving_radius;
			rr_s1 <= 32'(item.moving_radius) + 32'(item.fixed_radius);

			r2_s2 <= 64'(rr_s1 * rr_s1);
			mr_s2 <= mr_s1;

			a_s3  <= vsq_s2[0] + vsq_s2[1] + vsq_s2[2];
			l2_s3 <= lsq_s2[0] + lsq_s2[1] + lsq_s2[2];
			b_s3  <= 67'(lvv_s2[0]) + 67'(lvv_s2[1]) + 67'(lvv_s2[2]);
			r2_s3 <= r2_s2;
			mr_s3 <= mr_s2;

			// Stage 4: sign of b, inside or outside, early misses.
			sb_s4.miss    <= (a_s3 == '0) | (outside_c & bneg_c);
			sb_s4.outside <= outside_c;
			sb_s4.bneg    <= bneg_c;
			sb_s4.bmag    <= 66'(bneg_c ? -b_s3 : b_s3);
			sb_s4.a       <= a_s3;
			for (int i = 0; i < 3; i++) begin
				sb_s4.p[i] <= p_s3[i];
				sb_s4.v[i] <= v_s3[i];
				sb_s4.c[i] <= c_s3[i];
			end
			sb_s4.mr <= mr_s3;
			cmag_s4  <= outside_c ? (l2_s3 - r2_ext_c) : (r2_ext_c - l2_s3);

			// Stage 5: partial products of b*b and a*c.
			sb_s5    <= sb_s4;
			bb_ll_s5 <= 66'(sb_s4.bmag[32:0] * sb_s4.bmag[32:0]);
			bb_lh_s5 <= 66'(sb_s4.bmag[32:0] * sb_s4.bmag[65:33]);
			bb_hh_s5 <= 66'(sb_s4.bmag[65:33] * sb_s4.bmag[65:33]);
			ac_ll_s5 <= 65'(sb_s4.a[31:0] * cmag_s4[32:0]);
			ac_lh_s5 <= 65'(sb_s4.a[31:0] * cmag_s4[65:33]);
			ac_hl_s5 <= 65'(sb_s4.a[63:32] * cmag_s4[32:0]);
			ac_hh_s5 <= 65'(sb_s4.a[63:32] * cmag_s4[65:33]);

			// Stage 6: assemble the two wide products.
			sb_s6 <= sb_s5;
			bb_s6 <= 132'(bb_ll_s5) + (132'(bb_lh_s5) << 34) + (132'(bb_hh_s5) << 66);
			ac_s6 <= 130'(ac_ll_s5) + (130'(ac_lh_s5) << 33) + (130'(ac_hl_s5) << 32)
				+ (130'(ac_hh_s5) << 65);

			// Stage 7: discriminant.
			sb_s7      <= sb_pass_c;
			disc_s7    <= sb_s6.outside ? (134'(bb_s6) - 134'(ac_s6))
				: (134'(bb_s6) + 134'(ac_s6));
		end
	end

	assign out_vld = vld_s7;
	assign disc    = disc_s7;
	assign sb      = sb_s7;

endmodule

`default_nettype wire

// ----- hdl/mssht_place.sv -----
// Contact placement: moving centre at the hit time and squared length to the fixed centre.
// Six register stages; uses mssht_pkg types.
`default_nettype none

module mssht_place (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [mssht_pkg::T_W-1:0]     t,
	input  mssht_pkg::time_sb_t           tsb,
	output logic                          out_vld,
	output logic [mssht_pkg::LEN2_W-1:0]  len2,
	output mssht_pkg::norm_sb_t           nsb
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [64:0]  prod_s1 [3];
	mssht_pkg::time_sb_t tsb_s1, tsb_s2;
	logic [31:0]         t_s1, t_s2;

	mssht_pkg::pos_t     pc_c [3];
	mssht_pkg::pos_t     pc_s2 [3];
	logic signed [50:0]  dv_s2 [3];

	mssht_pkg::norm_sb_t nsb_s3, nsb_s4, nsb_s5, nsb_s6;
	logic [49:0]         ll_s4 [3], lh_s4 [3], hh_s4 [3];
	logic [99:0]         sq_s5 [3];
	logic [mssht_pkg::LEN2_W-1:0] len2_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pc_c[i] = 50'($signed(tsb_s1.p[i])) + 50'($signed(prod_s1[i][64:16]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tsb_s1 <= tsb;
			t_s1   <= t;
			tsb_s2 <= tsb_s1;
			t_s2   <= t_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= 65'($signed(tsb.v[i]) * $signed({1'b0, t}));
				pc_s2[i]   <= pc_c[i];
				dv_s2[i]   <= 51'(pc_c[i]) - 51'($signed(tsb_s1.c[i]));

				nsb_s3.pc[i]   <= pc_s2[i];
				nsb_s3.dneg[i] <= dv_s2[i][50];
				nsb_s3.dmag[i] <= 50'(dv_s2[i][50] ? -dv_s2[i] : dv_s2[i]);

				ll_s4[i] <= 50'(nsb_s3.dmag[i][24:0] * nsb_s3.dmag[i][24:0]);
				lh_s4[i] <= 50'(nsb_s3.dmag[i][24:0] * nsb_s3.dmag[i][49:25]);
				hh_s4[i] <= 50'(nsb_s3.dmag[i][49:25] * nsb_s3.dmag[i][49:25]);

				sq_s5[i] <= 100'(ll_s4[i]) + (100'(lh_s4[i]) << 26) + (100'(hh_s4[i]) << 50);
			end
			nsb_s3.miss <= tsb_s2.miss;
			nsb_s3.t    <= t_s2;
			nsb_s3.mr   <= tsb_s2.mr;
			nsb_s4      <= nsb_s3;
			nsb_s5      <= nsb_s4;
			nsb_s6      <= nsb_s5;
			len2_s6     <= 102'(sq_s5[0]) + 102'(sq_s5[1]) + 102'(sq_s5[2]);
		end
	end

	assign out_vld = vld_s6;
	assign len2    = len2_s6;
	assign nsb     = nsb_s6;

endmodule

`default_nettype wire

// ----- hdl/moving_sphere_sphere_hit_time_unit.sv -----
// Moving sphere against fixed sphere: first contact time, contact point and unit normal.
// The longest parts of the pipeline from an accepted query item to its result item are
// the two square roots (67 and 51 stages) and the two dividers (32 and 17 stages).
// Throughput is one item per cycle while the result side does not stall; a one-entry skid register on the output.
// Reset clears every valid bit, the skid register's among them; payload registers are not reset.
`default_nettype none

module moving_sphere_sphere_hit_time_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  query_valid,
	output logic                  query_stall,
	input  mssht_pkg::item_in_t   query,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mssht_pkg::item_out_t  result
);

	// The whole pipeline moves together. It stops only while the skid register holds an
	// item, so a stall on the result side costs no item and repeats none.
	logic                  en;
	logic                  skid_vld_q;
	mssht_pkg::item_out_t  skid_q;

	assign en = !skid_vld_q;

	// Front end: seven stages up to the discriminant of the grown-sphere quadratic.
	logic                          disc_vld;
	logic [mssht_pkg::DISC_W-1:0]  disc;
	mssht_pkg::root_sb_t           disc_sb;

	mssht_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (query_valid),
		.item    (query),
		.out_vld (disc_vld),
		.disc    (disc),
		.sb      (disc_sb)
	);

	// Square root of the discriminant, one root bit per stage.
	logic                          sq_vld;
	logic [mssht_pkg::ROOT_W-1:0]  sq_root;
	mssht_pkg::root_sb_t           sq_sb;

	mssht_isqrt_pipe #(
		.NW  (mssht_pkg::DISC_W),
		.SBW ($bits(mssht_pkg::root_sb_t))
	) u_disc_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (disc_vld),
		.radicand (disc),
		.sb_in    (disc_sb),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.sb_out   (sq_sb)
	);

	// Stage 1: numerator of the root. Outside the grown sphere the entry root is taken,
	// inside it (or on its surface) the exit root.
	logic                         vld_s1;
	logic [mssht_pkg::NUM_W-1:0]  num_s1;
	mssht_pkg::root_sb_t          rsb_s1;

	// Stage 2: the time is num*2^16/a; it only fits 32 bits when num/2^16 is below a,
	// and that same condition keeps the divider's starting remainder below the divisor.
	logic                         vld_s2;
	logic [mssht_pkg::A_W-1:0]    a_s2;
	logic [mssht_pkg::A_W-1:0]    r0_s2;
	logic [31:0]                  lo_s2;
	mssht_pkg::time_sb_t          tsb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sq_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsb_s1 <= sq_sb;
			if (sq_sb.outside) begin
				num_s1 <= 68'(sq_sb.bmag) - 68'(sq_root);
			end else if (sq_sb.bneg) begin
				num_s1 <= 68'(sq_root) - 68'(sq_sb.bmag);
			end else begin
				num_s1 <= 68'(sq_root) + 68'(sq_sb.bmag);
			end

			a_s2        <= rsb_s1.a;
			r0_s2       <= 64'(num_s1[67:16]);
			lo_s2       <= {num_s1[15:0], 16'h0000};
			tsb_s2.miss <= rsb_s1.miss | (64'(num_s1[67:16]) >= rsb_s1.a);
			tsb_s2.p    <= rsb_s1.p;
			tsb_s2.v    <= rsb_s1.v;
			tsb_s2.c    <= rsb_s1.c;
			tsb_s2.mr   <= rsb_s1.mr;
		end
	end

	// Time division: 32 quotient bits, one per stage.
	logic [mssht_pkg::A_W-1:0]  tdiv_r0 [1];
	logic [31:0]                tdiv_lo [1];
	logic [31:0]                tdiv_q  [1];
	logic                       t_vld;
	mssht_pkg::time_sb_t        t_sb;

	assign tdiv_r0[0] = r0_s2;
	assign tdiv_lo[0] = lo_s2;

	mssht_div_pipe #(
		.DW    (mssht_pkg::A_W),
		.QW    (mssht_pkg::T_W),
		.LANES (1),
		.SBW   ($bits(mssht_pkg::time_sb_t))
	) u_time_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.divisor (a_s2),
		.rem0    (tdiv_r0),
		.low     (tdiv_lo),
		.sb_in   (tsb_s2),
		.out_vld (t_vld),
		.quot    (tdiv_q),
		.sb_out  (t_sb)
	);

	// Moving centre at the hit time and its squared distance from the fixed centre.
	logic                          pl_vld;
	logic [mssht_pkg::LEN2_W-1:0]  len2;
	mssht_pkg::norm_sb_t           pl_sb;

	mssht_place u_place (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (t_vld),
		.t       (tdiv_q[0]),
		.tsb     (t_sb),
		.out_vld (pl_vld),
		.len2    (len2),
		.nsb     (pl_sb)
	);

	// Length of the centre difference.
	logic                         len_vld;
	logic [mssht_pkg::LEN_W-1:0]  len;
	mssht_pkg::norm_sb_t          len_sb;

	mssht_isqrt_pipe #(
		.NW  (mssht_pkg::LEN2_W),
		.SBW ($bits(mssht_pkg::norm_sb_t))
	) u_len_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (pl_vld),
		.radicand (len2),
		.sb_in    (pl_sb),
		.out_vld  (len_vld),
		.root     (len),
		.sb_out   (len_sb)
	);

	// Normal division, three lanes sharing the length as divisor. Each component
	// magnitude is at most the length, so the quotient needs 17 bits and the
	// starting remainder (the magnitude halved) is below the divisor.
	logic [mssht_pkg::LEN_W-1:0]  ndiv_r0 [3];
	logic [mssht_pkg::NQ_W-1:0]   ndiv_lo [3];
	logic [mssht_pkg::NQ_W-1:0]   ndiv_q  [3];
	mssht_pkg::tail_sb_t          ndiv_sb_in;
	mssht_pkg::tail_sb_t          n_sb;
	logic                         n_vld;

	for (genvar gl = 0; gl < 3; gl++) begin : g_ndiv_in
		assign ndiv_r0[gl] = 51'(len_sb.dmag[gl][49:1]);
		assign ndiv_lo[gl] = {len_sb.dmag[gl][0], 16'h0000};
	end

	assign ndiv_sb_in.miss  = len_sb.miss;
	assign ndiv_sb_in.lzero = (len == '0);
	assign ndiv_sb_in.t     = len_sb.t;
	assign ndiv_sb_in.pc    = len_sb.pc;
	assign ndiv_sb_in.dneg  = len_sb.dneg;
	assign ndiv_sb_in.mr    = len_sb.mr;

	mssht_div_pipe #(
		.DW    (mssht_pkg::LEN_W),
		.QW    (mssht_pkg::NQ_W),
		.LANES (3),
		.SBW   ($bits(mssht_pkg::tail_sb_t))
	) u_norm_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (len_vld),
		.divisor (len),
		.rem0    (ndiv_r0),
		.low     (ndiv_lo),
		.sb_in   (ndiv_sb_in),
		.out_vld (n_vld),
		.quot    (ndiv_q),
		.sb_out  (n_sb)
	);

	// Stage 3: signed normal; a moving centre exactly on the fixed centre gives zero.
	// Stage 4: moving radius times the normal.
	// Stage 5: contact point, saturated to 32 bits, and the result item.
	logic                  vld_s3, vld_s4, res_vld_s5;
	logic signed [17:0]    nv_s3 [3];
	logic signed [17:0]    nv_s4 [3];
	logic signed [49:0]    mrn_s4 [3];
	mssht_pkg::tail_sb_t   sb_s3, sb_s4;
	mssht_pkg::item_out_t  res_s5;

	logic signed [31:0]    mrs_c;
	logic signed [50:0]    loc_c [3];
	mssht_pkg::coord_t     loc_sat_c [3];
	mssht_pkg::coord_t     nrm_c [3];
	mssht_pkg::item_out_t  res_c;

	assign mrs_c = $signed({1'b0, sb_s3.mr});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			loc_c[i] = 51'(sb_s4.pc[i]) - 51'($signed(mrn_s4[i][49:16]));
			if (loc_c[i] > 51'sd2147483647) begin
				loc_sat_c[i] = 32'sh7FFFFFFF;
			end else if (loc_c[i] < -51'sd2147483648) begin
				loc_sat_c[i] = 32'sh80000000;
			end else begin
				loc_sat_c[i] = loc_c[i][31:0];
			end
			nrm_c[i] = {{14{nv_s4[i][17]}}, nv_s4[i]};
		end
		if (sb_s4.miss) begin
			res_c          = '0;
			res_c.hit_time = '1;
		end else begin
			res_c.hit      = 1'b1;
			res_c.hit_time = sb_s4.t;
			res_c.loc_x    = loc_sat_c[0];
			res_c.loc_y    = loc_sat_c[1];
			res_c.loc_z    = loc_sat_c[2];
			res_c.norm_x   = nrm_c[0];
			res_c.norm_y   = nrm_c[1];
			res_c.norm_z   = nrm_c[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			res_vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3     <= n_vld;
			vld_s4     <= vld_s3;
			res_vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3 <= n_sb;
			sb_s4 <= sb_s3;
			for (int i = 0; i < 3; i++) begin
				if (n_sb.lzero) begin
					nv_s3[i] <= '0;
				end else if (n_sb.dneg[i]) begin
					nv_s3[i] <= -$signed({1'b0, ndiv_q[i]});
				end else begin
					nv_s3[i] <= $signed({1'b0, ndiv_q[i]});
				end
				nv_s4[i]  <= nv_s3[i];
				mrn_s4[i] <= 50'(mrs_c * nv_s3[i]);
			end
			res_s5 <= res_c;
		end
	end

	// Output side: the skid register takes the last stage's item when it is stalled, which
	// lets the pipeline advance as the skid register fills; it then stops until that item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			skid_vld_q <= res_vld_s5 && result_stall;
		end else if (!result_stall) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= res_s5;
		end
	end

	assign query_stall  = skid_vld_q;
	assign result_valid = skid_vld_q | res_vld_s5;
	assign result       = skid_vld_q ? skid_q : res_s5;

	// The skid register only fills when a result item was offered and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(result_valid && result_stall))
		else $error("skid register filled without a stalled result item");

	// It only empties when its item was taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skid_vld_q) |-> $past(!result_stall))
		else $error("skid register emptied while the result was stalled");

	// A miss carries the saturated time and cleared geometry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.hit) |-> (result.hit_time == 32'hFFFFFFFF
			&& result.loc_x == '0 && result.norm_x == '0 && result.norm_z == '0))
		else $error("miss result item with non-cleared fields");

	// A unit normal component never exceeds one in Q16.16.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.hit) |-> (result.norm_x <= 32'sd65536
			&& result.norm_x >= -32'sd65536 && result.norm_y <= 32'sd65536
			&& result.norm_y >= -32'sd65536))
		else $error("normal component out of range");

endmodule

`default_nettype wire
